// File: src/json_string_unescaper_assert.svh
// Assertion macros shared by the unescaper checker.
`ifndef JSON_STRING_UNESCAPER_ASSERT_SVH
`define JSON_STRING_UNESCAPER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define JSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("unescaper check failed");

// Next-cycle implication, held off during reset.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("unescaper check failed");

`endif

// File: src/jsu_pkg.sv
// Package for the JSON string unescaper: word types, character codes, helpers.
`timescale 1ns / 1ps

package jsu_pkg;

    // Characters with a role in the escape syntax
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // UTF-8 encoding constants
    localparam logic [15:0] UTF8_LIM1  = 16'h0080;
    localparam logic [15:0] UTF8_LIM2  = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [5:0]  UTF8_MASK  = 6'h3F;

    localparam int HELD_DEPTH = 3;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_done;
    } t_out_word;

    typedef logic [HELD_DEPTH-1:0][7:0] t_held;

    // Up to three bytes produced by one input word
    typedef struct packed {
        logic [1:0]       cnt;
        logic [2:0][7:0]  b;
    } t_obuf;

    function automatic t_obuf obuf_put(t_obuf ob, logic [7:0] x);
        t_obuf r;
        r = ob;
        if (ob.cnt != 2'd3) begin
            r.b[ob.cnt] = x;
            r.cnt       = ob.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [7:0] map_escape(logic [7:0] e);
        logic [7:0] r;
        case (e)
            8'h6E:   r = 8'h0A; // n
            8'h74:   r = 8'h09; // t
            8'h72:   r = 8'h0D; // r
            8'h62:   r = 8'h08; // b
            8'h66:   r = 8'h0C; // f
            default: r = e;
        endcase
        return r;
    endfunction

    // Hex digit value; anything else counts as zero
    function automatic logic [3:0] hex_value(logic [7:0] c);
        logic [3:0] r;
        r = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = c[3:0] + 4'd9;
        end
        return r;
    endfunction

    function automatic t_obuf put_utf8(t_obuf ob, logic [15:0] cp);
        t_obuf r;
        r = ob;
        if (cp < UTF8_LIM1) begin
            r = obuf_put(r, cp[7:0]);
        end else if (cp < UTF8_LIM2) begin
            r = obuf_put(r, UTF8_LEAD2 | {3'b000, cp[10:6]});
            r = obuf_put(r, UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK});
        end else begin
            r = obuf_put(r, UTF8_LEAD3 | {4'h0, cp[15:12]});
            r = obuf_put(r, UTF8_CONT | {2'b00, cp[11:6] & UTF8_MASK});
            r = obuf_put(r, UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK});
        end
        return r;
    endfunction

    // Re-read an unfinished hex run as plain text at end of string.
    // Tail is held[0..hc-1] followed by the last byte.
    function automatic t_obuf replay_tail(t_held held, logic [1:0] hc, logic [7:0] lb);
        t_obuf            r;
        logic [2:0][7:0]  t;
        logic [2:0]       n;
        logic             skip;
        r    = '0;
        skip = 1'b0;
        n    = {1'b0, hc} + 3'd1;
        for (int i = 0; i < HELD_DEPTH; i++) begin
            t[i] = (2'(i) == hc) ? lb : held[i];
        end
        for (int i = 0; i < HELD_DEPTH; i++) begin
            if (3'(i) < n) begin
                if (skip) begin
                    skip = 1'b0;
                end else if (t[i] == CH_BSLASH && (3'(i) + 3'd1) < n) begin
                    skip = 1'b1;
                    if (t[(i + 1) % HELD_DEPTH] != CH_U) begin
                        r = obuf_put(r, map_escape(t[(i + 1) % HELD_DEPTH]));
                    end
                end else begin
                    r = obuf_put(r, t[i]);
                end
            end
        end
        return r;
    endfunction

endpackage

// File: src/json_string_unescaper.sv
// JSON string unescaper: escaped bytes in, unescaped UTF-8 bytes out.
//
//   channel | valid       | stall        | word
//   --------+-------------+--------------+------------------------
//   input   | i_in_valid  | o_in_stall   | i_in_word  (t_in_word)
//   output  | o_out_valid | i_out_stall  | o_out_word (t_out_word)
//
// One input word per cycle when each word makes at most one result and i_out_stall
// is low; a word that makes k results (a \u escape yields up to three UTF-8 bytes)
// holds the result register until all k are taken, which sets the input rate there.
// A word passes the input register, then is decoded into the result register.
// Reset is synchronous, active low, and returns the parser to plain text.
// Input stall follows from the output side combinationally through the
// result register's last entry.
`timescale 1ns / 1ps

module json_string_unescaper import jsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // input register
    logic      r_in_valid;
    t_in_word  r_in_word;

    // parser state
    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_accum, n_code_accum;
    t_held       r_held, n_held;

    // result register
    logic            r_res_valid;
    logic [2:0][7:0] r_res_byte;
    logic [1:0]      r_res_cnt;
    logic [1:0]      r_res_idx;
    logic            r_res_has;
    logic            r_res_last;

    logic       res_final;
    logic       res_free;
    logic       proc;
    logic       in_free;
    logic [7:0] cur_byte;
    logic       cur_last;
    t_obuf      ob;
    logic [15:0] acc;

    assign cur_byte = r_in_word.in_byte;
    assign cur_last = r_in_word.string_last;

    // handshake: result register frees on its final entry taken
    assign res_final = (r_res_idx == r_res_cnt - 2'd1);
    assign res_free  = !r_res_valid || (!i_out_stall && res_final);
    assign proc      = r_in_valid && res_free;
    assign in_free   = !r_in_valid || proc;
    assign o_in_stall = !in_free;

    // next parse mode
    always_comb begin
        case (r_mode)
            MODE_ESC: begin
                n_mode = (cur_byte == CH_U && !cur_last) ? MODE_HEX : MODE_NORMAL;
            end
            MODE_HEX: begin
                n_mode = (r_hex_count == 2'd3 || cur_last) ? MODE_NORMAL : MODE_HEX;
            end
            default: begin
                n_mode = (cur_byte == CH_BSLASH && !cur_last) ? MODE_ESC : MODE_NORMAL;
            end
        endcase
    end

    // decode one word into up to three bytes
    always_comb begin
        ob           = '0;
        n_hex_count  = r_hex_count;
        n_code_accum = r_code_accum;
        n_held       = r_held;
        acc          = {r_code_accum[11:0], hex_value(cur_byte)};
        case (r_mode)
            MODE_ESC: begin
                if (cur_byte != CH_U) begin
                    ob = obuf_put(ob, map_escape(cur_byte));
                end else if (!cur_last) begin
                    n_hex_count  = 2'd0;
                    n_code_accum = 16'd0;
                end
            end
            MODE_HEX: begin
                n_code_accum = acc;
                if (r_hex_count == 2'd3) begin
                    ob          = put_utf8(ob, acc);
                    n_hex_count = 2'd0;
                end else begin
                    n_held[r_hex_count] = cur_byte;
                    n_hex_count         = r_hex_count + 2'd1;
                    if (cur_last) begin
                        ob = replay_tail(r_held, r_hex_count, cur_byte);
                    end
                end
            end
            default: begin
                if (!(cur_byte == CH_BSLASH && !cur_last)) begin
                    ob = obuf_put(ob, cur_byte);
                end
            end
        endcase
        if (cur_last) begin
            n_hex_count  = 2'd0;
            n_code_accum = 16'd0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
        if (in_free && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_hex_count  <= 2'd0;
            r_code_accum <= 16'd0;
        end else if (proc) begin
            r_mode       <= n_mode;
            r_hex_count  <= n_hex_count;
            r_code_accum <= n_code_accum;
        end
        if (proc) begin
            r_held <= n_held;
        end
    end

    // result register: load on decode, step one entry per taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_res_idx   <= 2'd0;
        end else if (proc) begin
            r_res_idx   <= 2'd0;
            r_res_valid <= cur_last || (ob.cnt != 2'd0);
        end else if (r_res_valid && !i_out_stall) begin
            if (res_final) begin
                r_res_valid <= 1'b0;
            end else begin
                r_res_idx <= r_res_idx + 2'd1;
            end
        end
        if (proc) begin
            r_res_last <= cur_last;
            if (ob.cnt == 2'd0) begin
                // empty end marker
                r_res_byte <= '0;
                r_res_cnt  <= 2'd1;
                r_res_has  <= 1'b0;
            end else begin
                r_res_byte <= ob.b;
                r_res_cnt  <= ob.cnt;
                r_res_has  <= 1'b1;
            end
        end
    end

    // output word
    assign o_out_valid            = r_res_valid;
    assign o_out_word.out_byte    = (r_res_idx == 2'd3) ? 8'd0 : r_res_byte[r_res_idx];
    assign o_out_word.has_byte    = r_res_has;
    assign o_out_word.run_last    = res_final;
    assign o_out_word.string_done = res_final && r_res_last;

endmodule

// File: src/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
`timescale 1ns / 1ps
`include "json_string_unescaper_assert.svh"

module jsu_checker import jsu_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a stalled result word stays offered
    `JSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // end of string always closes a run
    `JSU_ASSERT_SAME(a_done_closes_run, i_clk, i_rst_n,
        o_out_valid && o_out_word.string_done, o_out_word.run_last)

    // an empty word is only the end marker, with a zero byte
    `JSU_ASSERT_SAME(a_empty_is_marker, i_clk, i_rst_n,
        o_out_valid && !o_out_word.has_byte,
        o_out_word.string_done && o_out_word.out_byte == 8'd0)

    // a stalled result word keeps its contents
    `JSU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n,
        o_out_valid && i_out_stall, $stable(o_out_word))

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the JSON string unescaper: directed and random escaped text.
`timescale 1ns / 1ps

module tb_top;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 135;
    localparam int SETTLE_TICKS = 10;

    // Escape letters and the control characters they stand for
    localparam logic [7:0] ESC_N    = 8'h6E;
    localparam logic [7:0] ESC_T    = 8'h74;
    localparam logic [7:0] ESC_R    = 8'h72;
    localparam logic [7:0] ESC_B    = 8'h62;
    localparam logic [7:0] ESC_F    = 8'h66;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int words_sent    = 0;
    int errors        = 0;
    int cycles        = 0;

    t_out_word expected_words [$];

    // Shadow parser state
    t_mode       pm_mode    = MODE_NORMAL;
    logic [1:0]  pm_hex_cnt = 2'd0;
    logic [15:0] pm_code    = 16'h0000;
    logic [7:0]  pm_held [0:2];

    json_string_unescaper u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    function automatic logic [7:0] escape_char(logic [7:0] e);
        logic [7:0] r;
        case (e)
            ESC_N:   r = CH_LF;
            ESC_T:   r = CH_TAB;
            ESC_R:   r = CH_CR;
            ESC_B:   r = CH_BS;
            ESC_F:   r = CH_FF;
            default: r = e;
        endcase
        return r;
    endfunction

    // Non-hex characters count as zero
    function automatic logic [3:0] hex_digit(logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] nibble_char(logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + 8'(v);
        end else if ($urandom_range(0, 1) == 0) begin
            r = 8'h57 + 8'(v);
        end else begin
            r = 8'h37 + 8'(v);
        end
        return r;
    endfunction

    // Work out the output words for one accepted input word
    task automatic decode_word(input t_in_word w);
        logic [7:0] made [$];
        logic [7:0] c;
        logic       fin;
        int         n;
        int         i;
        t_out_word  r;
        c   = w.in_byte;
        fin = w.string_last;
        case (pm_mode)
            MODE_ESC: begin
                pm_mode = MODE_NORMAL;
                if (c == CH_U) begin
                    if (!fin) begin
                        pm_mode    = MODE_HEX;
                        pm_hex_cnt = 2'd0;
                        pm_code    = 16'h0000;
                    end
                end else begin
                    made.push_back(escape_char(c));
                end
            end
            MODE_HEX: begin
                pm_code = {pm_code[11:0], hex_digit(c)};
                if (pm_hex_cnt == 2'd3) begin
                    // code point out as UTF-8
                    if (pm_code < UTF8_LIM1) begin
                        made.push_back(pm_code[7:0]);
                    end else if (pm_code < UTF8_LIM2) begin
                        made.push_back(UTF8_LEAD2 | 8'(pm_code[10:6]));
                        made.push_back(UTF8_CONT | 8'(pm_code[5:0]));
                    end else begin
                        made.push_back(UTF8_LEAD3 | 8'(pm_code[15:12]));
                        made.push_back(UTF8_CONT | 8'(pm_code[11:6]));
                        made.push_back(UTF8_CONT | 8'(pm_code[5:0]));
                    end
                    pm_mode    = MODE_NORMAL;
                    pm_hex_cnt = 2'd0;
                end else begin
                    pm_held[pm_hex_cnt] = c;
                    pm_hex_cnt = pm_hex_cnt + 2'd1;
                    if (fin) begin
                        // string ended mid-run: drop the escape, reread the tail as text
                        n = int'(pm_hex_cnt);
                        i = 0;
                        while (i < n) begin
                            if (pm_held[i] == CH_BSLASH && i + 1 < n) begin
                                if (pm_held[i + 1] != CH_U) begin
                                    made.push_back(escape_char(pm_held[i + 1]));
                                end
                                i += 2;
                            end else begin
                                made.push_back(pm_held[i]);
                                i += 1;
                            end
                        end
                    end
                end
            end
            default: begin
                pm_mode = MODE_NORMAL;
                if (c == CH_BSLASH && !fin) begin
                    pm_mode = MODE_ESC;
                end else begin
                    made.push_back(c);
                end
            end
        endcase

        if (fin) begin
            pm_mode    = MODE_NORMAL;
            pm_hex_cnt = 2'd0;
            pm_code    = 16'h0000;
            if (made.size() == 0) begin
                r = '{out_byte: 8'h00, has_byte: 1'b0, run_last: 1'b1, string_done: 1'b1};
                expected_words.push_back(r);
            end
        end
        for (int k = 0; k < made.size(); k++) begin
            r.out_byte    = made[k];
            r.has_byte    = 1'b1;
            r.run_last    = (k == made.size() - 1);
            r.string_done = (k == made.size() - 1) && fin;
            expected_words.push_back(r);
        end
    endtask

    // Handshake monitor: predict on input, compare on output
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                decode_word(in_word);
            end
            if (o_out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected word: expected none, ",
                              "got byte %h has %b last %b done %b"},
                             $time, o_out_word.out_byte, o_out_word.has_byte,
                             o_out_word.run_last, o_out_word.string_done);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_out_word.out_byte !== exp_w.out_byte ||
                        o_out_word.has_byte !== exp_w.has_byte ||
                        o_out_word.run_last !== exp_w.run_last ||
                        o_out_word.string_done !== exp_w.string_done) begin
                        errors++;
                        $display({"%0t: mismatch: expected byte %h has %b last %b done %b, ",
                                  "got byte %h has %b last %b done %b"},
                                 $time, exp_w.out_byte, exp_w.has_byte, exp_w.run_last,
                                 exp_w.string_done, o_out_word.out_byte,
                                 o_out_word.has_byte, o_out_word.run_last,
                                 o_out_word.string_done);
                    end
                end
            end
        end
    end

    // Offer one word, with random idle cycles ahead of it; returns on acceptance
    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_word('{in_byte: s[i], string_last: (i == s.len() - 1)});
        end
    endtask

    // Hold the input idle until every predicted word has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One random string: mostly well-formed escapes, some noise, sometimes cut short
    task automatic send_random_text();
        logic [7:0]  chars [$];
        logic [15:0] code;
        int          kind;
        int          cut;
        repeat ($urandom_range(1, 4)) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                chars.push_back(8'($urandom));
            end else if (kind < 6) begin
                chars.push_back(CH_BSLASH);
                case ($urandom_range(0, 8))
                    0: chars.push_back(ESC_N);
                    1: chars.push_back(ESC_T);
                    2: chars.push_back(ESC_R);
                    3: chars.push_back(ESC_B);
                    4: chars.push_back(ESC_F);
                    5: chars.push_back(CH_SLASH);
                    6: chars.push_back(CH_QUOTE);
                    7: chars.push_back(CH_BSLASH);
                    default: chars.push_back(8'($urandom));
                endcase
            end else begin
                chars.push_back(CH_BSLASH);
                chars.push_back(CH_U);
                case ($urandom_range(0, 2))
                    0: code = 16'($urandom_range(0, 16'h007F));
                    1: code = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                for (int i = 3; i >= 0; i--) begin
                    if (kind == 9) begin
                        chars.push_back(8'($urandom));
                    end else begin
                        chars.push_back(nibble_char(code[i*4 +: 4]));
                    end
                end
            end
        end
        // cut short now and then so strings end inside an escape or hex run
        if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, chars.size());
        end else begin
            cut = chars.size();
        end
        for (int i = 0; i < cut; i++) begin
            send_word('{in_byte: chars[i], string_last: (i == cut - 1)});
        end
    endtask

    // Control-character escapes, ending on an escaped backslash
    task automatic test_escape_codes();
        send_chars("\\n\\t\\r\\b\\f\\\\");
    endtask

    // Largest code point, mixed-case hex, three-byte output
    task automatic test_utf8_extreme();
        send_chars("\\uFfFf");
    endtask

    task automatic test_trailing_backslash();
        send_chars("\\");
    endtask

    // Backslash-u as the last word gives only the empty end marker
    task automatic test_escape_u_last();
        send_chars("\\u");
    endtask

    // Hex run cut off; the reread tail is itself a dropped backslash-u
    task automatic test_unfinished_hex();
        send_chars("\\u\\u");
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_words);
        int target;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        target         = words_sent + n_words;
        while (words_sent < target) begin
            send_random_text();
        end
    endtask

    initial begin
        src_idle_pct   = 12;
        sink_stall_pct = 88;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_escape_codes();
        test_utf8_extreme();
        test_trailing_backslash();
        test_escape_u_last();
        test_unfinished_hex();

        test_random_traffic(12, 88, PHASE_WORDS);
        wait_drained();
        test_random_traffic(88, 12, PHASE_WORDS);
        wait_drained();
        test_random_traffic(0, 0, PHASE_WORDS);
        wait_drained();

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
